// ===== rtl/core/tcft_pkg.sv =====
// tcft_pkg: shared types, rate codes and constants for the timecode to frame time converter
// no dependencies; used by every module under rtl/core
package tcft_pkg;

  typedef enum logic [3:0] {
    RATE_UNKNOWN = 4'd0,
    RATE_23_976  = 4'd1,
    RATE_24      = 4'd2,
    RATE_25      = 4'd3,
    RATE_29_97   = 4'd4,
    RATE_30      = 4'd5,
    RATE_50      = 4'd6,
    RATE_59_94   = 4'd7,
    RATE_60      = 4'd8
  } rate_code_t;

  localparam int unsigned OPND_W  = 24;
  localparam int unsigned MULT_W  = 16;
  localparam int unsigned TAIL_W  = 17;
  localparam int unsigned SEC_W   = 17;
  localparam int unsigned COUNT_W = 32;
  localparam int unsigned SCALE_W = 16;

  localparam logic [MULT_W-1:0] FRAME_MILLI = 16'd1000;
  localparam logic [TAIL_W-1:0] HALF_FRAME  = 17'd500;

  localparam logic [OPND_W-1:0] DF24_HOUR = 24'd86292;
  localparam logic [OPND_W-1:0] DF24_MIN  = 24'd1438;
  localparam logic [OPND_W-1:0] DF24_SEC  = 24'd24;
  localparam logic [OPND_W-1:0] DF30_HOUR = 24'd107892;
  localparam logic [OPND_W-1:0] DF30_MIN  = 24'd1798;
  localparam logic [OPND_W-1:0] DF30_SEC  = 24'd30;
  localparam logic [OPND_W-1:0] DF60_HOUR = 24'd215892;
  localparam logic [OPND_W-1:0] DF60_MIN  = 24'd3598;
  localparam logic [OPND_W-1:0] DF60_SEC  = 24'd60;

  localparam logic [SCALE_W-1:0] SCALE_ERR   = 16'd1;
  localparam logic [SCALE_W-1:0] SCALE_23976 = 16'd23976;
  localparam logic [SCALE_W-1:0] SCALE_24000 = 16'd24000;
  localparam logic [SCALE_W-1:0] SCALE_25000 = 16'd25000;
  localparam logic [SCALE_W-1:0] SCALE_29970 = 16'd29970;
  localparam logic [SCALE_W-1:0] SCALE_30000 = 16'd30000;
  localparam logic [SCALE_W-1:0] SCALE_50000 = 16'd50000;
  localparam logic [SCALE_W-1:0] SCALE_59940 = 16'd59940;
  localparam logic [SCALE_W-1:0] SCALE_60000 = 16'd60000;

  typedef struct packed {
    logic [3:0] rate_type;
    logic       drop_flag;
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic [5:0] frame_number;
    logic [5:0] extra_frames;
    logic       field_index;
  } in_word_t;

  typedef struct packed {
    logic signed [COUNT_W-1:0] count_value;
    logic [SCALE_W-1:0]        time_scale;
    logic                      bad_rate;
  } out_word_t;

  // operands handed from the prepare stage to the multiply stage
  typedef struct packed {
    logic               valid;
    logic [OPND_W-1:0]  opnd;
    logic [MULT_W-1:0]  mult;
    logic [TAIL_W-1:0]  tail;
    logic [SCALE_W-1:0] scale;
    logic               bad;
  } stage_t;

  // minutes / 10 for values below 64
  function automatic logic [2:0] tens_of(input logic [5:0] m);
    logic [13:0] p;
    p = 14'(m) * 14'd205;
    return p[13:11];
  endfunction

  function automatic logic [OPND_W-1:0] drop_frames(
    input logic [4:0]        h,
    input logic [5:0]        m,
    input logic [5:0]        s,
    input logic [6:0]        frames,
    input logic [OPND_W-1:0] per_hour,
    input logic [OPND_W-1:0] per_min,
    input logic [OPND_W-1:0] per_sec
  );
    logic [OPND_W-1:0] f;
    f = OPND_W'(h) * per_hour + OPND_W'(m) * per_min
        + (OPND_W'(tens_of(m)) << 1) + OPND_W'(s) * per_sec + OPND_W'(frames);
    return f;
  endfunction

endpackage

// ===== rtl/core/timecode_to_frame_time.sv =====
// timecode_to_frame_time: top level, input register then prepare and multiply stages
// a word passes the input register, the prepare register and the result register in turn; one word per cycle
// busy is tied low, a word can be taken at every edge; results cannot be stalled
// synchronous active-low reset clears the valid pipeline, payload registers are not reset
// depends on tcft_pkg, tcft_prep, tcft_scale
module timecode_to_frame_time (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  tcft_pkg::in_word_t  in_data,
  output logic                out_strobe,
  output tcft_pkg::out_word_t out_data
);

  logic               in_valid_r;
  tcft_pkg::in_word_t in_word_r;
  tcft_pkg::stage_t   stage_q;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    in_word_r <= in_data;
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= start && !busy;
    end
  end

  tcft_prep u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid_r),
    .in_word  (in_word_r),
    .stage_q  (stage_q)
  );

  tcft_scale u_scale (
    .clk        (clk),
    .rst_n      (rst_n),
    .stage_q    (stage_q),
    .out_strobe (out_strobe),
    .out_word   (out_data)
  );

endmodule

// ===== rtl/core/tcft_prep.sv =====
// tcft_prep: decodes the rate and forms multiply operands for one timecode word
// depends on tcft_pkg
module tcft_prep (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  tcft_pkg::in_word_t in_word,
  output tcft_pkg::stage_t  stage_q
);

  tcft_pkg::stage_t stage_r, stage_nxt;

  logic [6:0]                   frames;
  logic [tcft_pkg::SEC_W-1:0]   total_sec;
  logic [tcft_pkg::TAIL_W-1:0]  half;
  logic [tcft_pkg::TAIL_W-1:0]  tail_nd;

  assign frames    = 7'(in_word.frame_number) + 7'(in_word.extra_frames);
  assign total_sec = tcft_pkg::SEC_W'(in_word.hours) * 17'd3600
                     + tcft_pkg::SEC_W'(in_word.minutes) * 17'd60
                     + tcft_pkg::SEC_W'(in_word.seconds);
  assign half      = in_word.field_index ? tcft_pkg::HALF_FRAME : '0;
  assign tail_nd   = tcft_pkg::TAIL_W'(frames) * 17'd1000 + half;

  always_comb begin
    stage_nxt.valid = in_valid;
    stage_nxt.bad   = 1'b0;
    stage_nxt.opnd  = tcft_pkg::OPND_W'(total_sec);
    stage_nxt.tail  = tail_nd;
    stage_nxt.mult  = tcft_pkg::SCALE_24000;
    stage_nxt.scale = tcft_pkg::SCALE_24000;
    case (in_word.rate_type)
      tcft_pkg::RATE_23_976: begin
        stage_nxt.scale = tcft_pkg::SCALE_23976;
        if (in_word.drop_flag) begin
          stage_nxt.opnd = tcft_pkg::drop_frames(in_word.hours, in_word.minutes,
                             in_word.seconds, frames, tcft_pkg::DF24_HOUR,
                             tcft_pkg::DF24_MIN, tcft_pkg::DF24_SEC);
          stage_nxt.mult = tcft_pkg::FRAME_MILLI;
          stage_nxt.tail = half;
        end else begin
          stage_nxt.mult = tcft_pkg::SCALE_24000;
        end
      end
      tcft_pkg::RATE_29_97: begin
        stage_nxt.scale = tcft_pkg::SCALE_29970;
        if (in_word.drop_flag) begin
          stage_nxt.opnd = tcft_pkg::drop_frames(in_word.hours, in_word.minutes,
                             in_word.seconds, frames, tcft_pkg::DF30_HOUR,
                             tcft_pkg::DF30_MIN, tcft_pkg::DF30_SEC);
          stage_nxt.mult = tcft_pkg::FRAME_MILLI;
          stage_nxt.tail = half;
        end else begin
          stage_nxt.mult = tcft_pkg::SCALE_30000;
        end
      end
      tcft_pkg::RATE_59_94: begin
        stage_nxt.scale = tcft_pkg::SCALE_59940;
        if (in_word.drop_flag) begin
          stage_nxt.opnd = tcft_pkg::drop_frames(in_word.hours, in_word.minutes,
                             in_word.seconds, frames, tcft_pkg::DF60_HOUR,
                             tcft_pkg::DF60_MIN, tcft_pkg::DF60_SEC);
          stage_nxt.mult = tcft_pkg::FRAME_MILLI;
          stage_nxt.tail = half;
        end else begin
          stage_nxt.mult = tcft_pkg::SCALE_60000;
        end
      end
      tcft_pkg::RATE_24: begin
        stage_nxt.scale = tcft_pkg::SCALE_24000;
        stage_nxt.mult  = tcft_pkg::SCALE_24000;
      end
      tcft_pkg::RATE_25: begin
        stage_nxt.scale = tcft_pkg::SCALE_25000;
        stage_nxt.mult  = tcft_pkg::SCALE_25000;
      end
      tcft_pkg::RATE_30: begin
        stage_nxt.scale = tcft_pkg::SCALE_30000;
        stage_nxt.mult  = tcft_pkg::SCALE_30000;
      end
      tcft_pkg::RATE_50: begin
        stage_nxt.scale = tcft_pkg::SCALE_50000;
        stage_nxt.mult  = tcft_pkg::SCALE_50000;
      end
      tcft_pkg::RATE_60: begin
        stage_nxt.scale = tcft_pkg::SCALE_60000;
        stage_nxt.mult  = tcft_pkg::SCALE_60000;
      end
      default: begin
        stage_nxt.bad   = 1'b1;
        stage_nxt.opnd  = '0;
        stage_nxt.mult  = '0;
        stage_nxt.tail  = '0;
        stage_nxt.scale = tcft_pkg::SCALE_ERR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r.valid <= 1'b0;
    end else begin
      stage_r.valid <= stage_nxt.valid;
    end
    stage_r.opnd  <= stage_nxt.opnd;
    stage_r.mult  <= stage_nxt.mult;
    stage_r.tail  <= stage_nxt.tail;
    stage_r.scale <= stage_nxt.scale;
    stage_r.bad   <= stage_nxt.bad;
  end

  assign stage_q = stage_r;

endmodule

// ===== rtl/core/tcft_scale.sv =====
// tcft_scale: multiplies the prepared operand, adds the tail and registers the result word
// depends on tcft_pkg
module tcft_scale (
  input  logic               clk,
  input  logic               rst_n,
  input  tcft_pkg::stage_t   stage_q,
  output logic               out_strobe,
  output tcft_pkg::out_word_t out_word
);

  logic [tcft_pkg::OPND_W+tcft_pkg::MULT_W-1:0] prod;
  logic [tcft_pkg::COUNT_W-1:0]                 count;

  logic                 strobe_r;
  tcft_pkg::out_word_t  word_r, word_nxt;

  assign prod  = tcft_pkg::OPND_W'(stage_q.opnd) * tcft_pkg::MULT_W'(stage_q.mult);
  assign count = prod[tcft_pkg::COUNT_W-1:0] + tcft_pkg::COUNT_W'(stage_q.tail);

  always_comb begin
    word_nxt.count_value = count;
    word_nxt.time_scale  = stage_q.scale;
    word_nxt.bad_rate    = stage_q.bad;
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= stage_q.valid;
    end
  end

  assign out_strobe = strobe_r;
  assign out_word   = word_r;

endmodule

// ===== rtl/core/tcft_check.sv =====
// tcft_check: port-level assertions for timecode_to_frame_time, bound to the top level
// depends on tcft_pkg and timecode_to_frame_time
module tcft_check (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input tcft_pkg::in_word_t  in_data,
  input logic                out_strobe,
  input tcft_pkg::out_word_t out_data
);

  a_strobe_follows_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy, 3))
    else $error("result strobe without an accepted word");

  a_bad_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_data.bad_rate) |->
      (out_data.time_scale == tcft_pkg::SCALE_ERR && out_data.count_value == '0))
    else $error("bad rate result not cleared");

  a_bad_from_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |->
      (out_data.bad_rate == ($past(in_data.rate_type, 3) == tcft_pkg::RATE_UNKNOWN ||
                             $past(in_data.rate_type, 3) > tcft_pkg::RATE_60)))
    else $error("bad rate flag does not match rate code");

  a_good_scale: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_data.bad_rate) |->
      (out_data.time_scale >= tcft_pkg::SCALE_23976))
    else $error("scale out of range for a known rate");

endmodule

bind timecode_to_frame_time tcft_check u_check (.*);

// ===== tb/timecode_to_frame_time_test.sv =====
// testbench for timecode_to_frame_time: directed then random timecodes, results checked in order
// frame_time_checker predicts count, scale and error flag per timecode word
// depends on tcft_pkg and the timecode_to_frame_time rtl

class frame_time_checker;
  tcft_pkg::out_word_t expected_times[$];
  int unsigned         mismatches;
  int unsigned         results_seen;

  function new();
    mismatches   = 0;
    results_seen = 0;
  endfunction

  static function logic [31:0] drop_count(
    input logic [31:0] per_hour, per_min, per_sec, h, m, s, frames, field
  );
    logic [31:0] f;
    f = h * per_hour + m * per_min + (m / 32'd10) * 32'd2 + s * per_sec + frames;
    return f * 32'd1000 + field * 32'd500;
  endfunction

  static function tcft_pkg::out_word_t frame_time_of(input tcft_pkg::in_word_t w);
    logic [31:0]         h, m, s, frames, field, secs, tail, count;
    tcft_pkg::out_word_t r;
    h      = 32'(w.hours);
    m      = 32'(w.minutes);
    s      = 32'(w.seconds);
    frames = 32'(w.frame_number) + 32'(w.extra_frames);
    field  = 32'(w.field_index);
    secs   = h * 32'd3600 + m * 32'd60 + s;
    tail   = frames * 32'd1000 + field * 32'd500;
    r.bad_rate = 1'b0;
    case (tcft_pkg::rate_code_t'(w.rate_type))
      tcft_pkg::RATE_23_976: begin
        r.time_scale = 16'd23976;
        count = w.drop_flag ? drop_count(86292, 1438, 24, h, m, s, frames, field)
                            : secs * 32'd24000 + tail;
      end
      tcft_pkg::RATE_29_97: begin
        r.time_scale = 16'd29970;
        count = w.drop_flag ? drop_count(107892, 1798, 30, h, m, s, frames, field)
                            : secs * 32'd30000 + tail;
      end
      tcft_pkg::RATE_59_94: begin
        r.time_scale = 16'd59940;
        count = w.drop_flag ? drop_count(215892, 3598, 60, h, m, s, frames, field)
                            : secs * 32'd60000 + tail;
      end
      tcft_pkg::RATE_24: begin
        r.time_scale = 16'd24000;
        count = secs * 32'd24000 + tail;
      end
      tcft_pkg::RATE_25: begin
        r.time_scale = 16'd25000;
        count = secs * 32'd25000 + tail;
      end
      tcft_pkg::RATE_30: begin
        r.time_scale = 16'd30000;
        count = secs * 32'd30000 + tail;
      end
      tcft_pkg::RATE_50: begin
        r.time_scale = 16'd50000;
        count = secs * 32'd50000 + tail;
      end
      tcft_pkg::RATE_60: begin
        r.time_scale = 16'd60000;
        count = secs * 32'd60000 + tail;
      end
      default: begin
        r.time_scale = 16'd1;
        r.bad_rate   = 1'b1;
        count        = 32'd0;
      end
    endcase
    r.count_value = count;
    return r;
  endfunction

  function void note_timecode(input tcft_pkg::in_word_t w);
    expected_times.push_back(frame_time_of(w));
  endfunction

  function void check_result(input tcft_pkg::out_word_t got);
    tcft_pkg::out_word_t want;
    results_seen++;
    if (expected_times.size() == 0) begin
      $error("result word with nothing pending: count_value %0d", got.count_value);
      mismatches++;
      return;
    end
    want = expected_times.pop_front();
    if (got.count_value !== want.count_value) begin
      $error("count_value: expected %0d, actual %0d", want.count_value, got.count_value);
      mismatches++;
    end
    if (got.time_scale !== want.time_scale) begin
      $error("time_scale: expected %0d, actual %0d", want.time_scale, got.time_scale);
      mismatches++;
    end
    if (got.bad_rate !== want.bad_rate) begin
      $error("bad_rate: expected %0b, actual %0b", want.bad_rate, got.bad_rate);
      mismatches++;
    end
  endfunction
endclass

module timecode_to_frame_time_test;
  timeunit 1ns;
  timeprecision 1ps;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                start;
  logic                busy;
  tcft_pkg::in_word_t  in_data;
  logic                out_strobe;
  tcft_pkg::out_word_t out_data;

  frame_time_checker  board;
  int unsigned        timecodes_sent;
  int unsigned        drop_sent;
  int unsigned        unknown_sent;
  tcft_pkg::in_word_t directed[$];

  timecode_to_frame_time i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_strobe === 1'b1) begin
      board.check_result(out_data);
    end
  end

  function automatic tcft_pkg::in_word_t make_tc(
    input logic [3:0]  rate,
    input int unsigned drop,
    input int unsigned h,
    input int unsigned m, s, f, e,
    input int unsigned fld
  );
    tcft_pkg::in_word_t w;
    w.rate_type    = rate;
    w.drop_flag    = 1'(drop);
    w.hours        = 5'(h);
    w.minutes      = 6'(m);
    w.seconds      = 6'(s);
    w.frame_number = 6'(f);
    w.extra_frames = 6'(e);
    w.field_index  = 1'(fld);
    return w;
  endfunction

  function automatic tcft_pkg::in_word_t random_timecode();
    tcft_pkg::in_word_t w;
    int unsigned        pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      w.rate_type    = 4'($urandom);
      w.drop_flag    = 1'($urandom);
      w.hours        = 5'($urandom);
      w.minutes      = 6'($urandom);
      w.seconds      = 6'($urandom);
      w.frame_number = 6'($urandom);
      w.extra_frames = 6'($urandom);
      w.field_index  = 1'($urandom);
    end else begin
      w.rate_type    = (pick == 1) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(1, 8));
      w.drop_flag    = 1'($urandom);
      w.hours        = 5'($urandom_range(0, 23));
      w.minutes      = 6'($urandom_range(0, 59));
      w.seconds      = 6'($urandom_range(0, 59));
      w.frame_number = 6'($urandom_range(0, 59));
      w.extra_frames = ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'd0;
      w.field_index  = 1'($urandom);
    end
    return w;
  endfunction

  task automatic send_timecode(input tcft_pkg::in_word_t w);
    start   <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_timecode(w);
    timecodes_sent++;
    if (w.rate_type == tcft_pkg::RATE_UNKNOWN || w.rate_type > tcft_pkg::RATE_60) begin
      unknown_sent++;
    end else if (w.drop_flag) begin
      drop_sent++;
    end
  endtask

  task automatic hold_off(input int unsigned n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (board.expected_times.size() != 0) @(posedge clk);
  endtask

  initial begin
    board          = new();
    timecodes_sent = 0;
    drop_sent      = 0;
    unknown_sent   = 0;
    rst_n          = 1'b0;
    start          = 1'b0;
    in_data        = '0;

    directed.push_back(make_tc(tcft_pkg::RATE_UNKNOWN, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(make_tc(4'hF, 1, 31, 63, 63, 63, 63, 1));
    directed.push_back(make_tc(4'h9, 0, 1, 2, 3, 4, 5, 0));
    directed.push_back(make_tc(tcft_pkg::RATE_23_976, 1, 23, 59, 59, 23, 0, 1));
    directed.push_back(make_tc(tcft_pkg::RATE_23_976, 0, 23, 59, 59, 23, 0, 1));
    directed.push_back(make_tc(tcft_pkg::RATE_29_97, 1, 23, 59, 59, 29, 0, 1));
    directed.push_back(make_tc(tcft_pkg::RATE_29_97, 0, 23, 59, 59, 29, 0, 1));
    directed.push_back(make_tc(tcft_pkg::RATE_59_94, 1, 23, 59, 59, 59, 0, 1));
    directed.push_back(make_tc(tcft_pkg::RATE_59_94, 0, 23, 59, 59, 59, 0, 1));
    directed.push_back(make_tc(tcft_pkg::RATE_59_94, 1, 0, 0, 0, 0, 0, 0));
    directed.push_back(make_tc(tcft_pkg::RATE_29_97, 1, 0, 9, 0, 0, 0, 0));
    directed.push_back(make_tc(tcft_pkg::RATE_29_97, 1, 0, 10, 0, 0, 0, 0));
    directed.push_back(make_tc(tcft_pkg::RATE_29_97, 1, 1, 63, 0, 2, 0, 0));
    directed.push_back(make_tc(tcft_pkg::RATE_24, 1, 12, 30, 15, 10, 3, 1));
    directed.push_back(make_tc(tcft_pkg::RATE_25, 1, 5, 0, 0, 24, 0, 0));
    directed.push_back(make_tc(tcft_pkg::RATE_30, 1, 23, 59, 59, 29, 0, 1));
    directed.push_back(make_tc(tcft_pkg::RATE_50, 0, 31, 63, 63, 63, 63, 1));
    directed.push_back(make_tc(tcft_pkg::RATE_60, 1, 31, 63, 63, 63, 63, 1));
    directed.push_back(make_tc(tcft_pkg::RATE_59_94, 1, 31, 63, 63, 63, 63, 1));
    directed.push_back(make_tc(tcft_pkg::RATE_29_97, 0, 31, 63, 63, 63, 63, 0));
    directed.push_back(make_tc(tcft_pkg::RATE_23_976, 1, 31, 63, 63, 0, 63, 0));
    directed.push_back(make_tc(tcft_pkg::RATE_60, 0, 0, 0, 0, 0, 0, 1));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[k]) send_timecode(directed[k]);

    for (int i = 0; i < 1680; i++) begin
      if (i == 800) begin
        drain_results();
      end else if (i < 1400 && (i / 120) % 3 != 0 && $urandom_range(0, 3) == 0) begin
        hold_off($urandom_range(1, 7));
      end
      send_timecode(random_timecode());
    end

    drain_results();
    repeat (10) @(posedge clk);

    $display("%0d timecodes sent (%0d drop-frame, %0d unknown rate), %0d result words checked",
             timecodes_sent, drop_sent, unknown_sent, board.results_seen);
    $display("%0d mismatches found", board.mismatches);
    if (board.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #400_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
